// ===== rtl/core/software_timer_table_assert.svh =====
// Assertion macros used by the timer table back end
`ifndef SOFTWARE_TIMER_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_TABLE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset
`define STT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("timer table check failed");

// Next-cycle implication, checked outside reset
`define STT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("timer table check failed");

`else

`define STT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define STT_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/stt_pkg.sv =====
// Shared types, codes and constants of the software timer table
`timescale 1ns / 1ps

package stt_pkg;

    // Default sizes of the table
    localparam int SLOTS_DEF      = 32;
    localparam int KEY_BITS_DEF   = 8;
    localparam int COUNT_BITS_DEF = 24;

    // Fixed field widths on the streams
    localparam int KEY_W = 8;
    localparam int DUR_W = 24;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Round down to a multiple of ten: q = (x * ceil(2^27 / 10)) >> 27 is exact for 24 bits
    localparam int unsigned ROUND_STEP  = 10;
    localparam int          RECIP_SHIFT = 27;
    localparam logic [DUR_W-1:0] RECIP_MUL =
        DUR_W'(((64'd1 << RECIP_SHIFT) + 64'(ROUND_STEP) - 64'd1) / 64'(ROUND_STEP));

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_START  = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        EV_START  = 2'd0,
        EV_DELETE = 2'd1,
        EV_EXPIRY = 2'd2,
        EV_READ   = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } back_state_t;

    // Classified request handed from front to back
    typedef struct packed {
        req_t             req;
        logic [KEY_W-1:0] key;
        logic [DUR_W-1:0] count;
    } cmd_t;

    // One result item
    typedef struct packed {
        event_t           kind;
        logic             ok;
        logic [KEY_W-1:0] key;
        logic [DUR_W-1:0] remaining;
        logic             last;
    } result_t;

endpackage

// ===== rtl/core/stt_front.sv =====
// Front end: accepts request items, saturates and rounds the duration
`timescale 1ns / 1ps

module stt_front #(
    parameter int COUNT_BITS = stt_pkg::COUNT_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  stt_pkg::req_t              in_req,
    input  logic [stt_pkg::KEY_W-1:0]  in_key,
    input  logic [stt_pkg::DUR_W-1:0]  in_duration,
    output logic                       cmd_valid,
    input  logic                       cmd_ready,
    output stt_pkg::cmd_t              cmd
);
    import stt_pkg::*;

    localparam int PROD_W = 2 * DUR_W;
    localparam int QUOT_W = PROD_W - RECIP_SHIFT;
    // Largest count the table holds, seen in duration width
    localparam logic [DUR_W-1:0] SAT_LIM = (COUNT_BITS >= DUR_W) ? {DUR_W{1'b1}} :
        DUR_W'((64'd1 << COUNT_BITS) - 64'd1);

    logic              stg_valid_reg;
    req_t              stg_req_reg;
    logic [KEY_W-1:0]  stg_key_reg;
    logic [PROD_W-1:0] stg_prod_reg;

    logic [DUR_W-1:0]  sat_dur;
    logic [QUOT_W-1:0] quot;
    logic              accept;

    // Clamp to the counter range
    assign sat_dur = (in_duration > SAT_LIM) ? SAT_LIM : in_duration;

    assign in_ready = !stg_valid_reg || cmd_ready;
    assign accept   = in_valid && in_ready;

    // Stage register: hold the item and the reciprocal product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (accept) begin
            stg_valid_reg <= 1'b1;
        end else if (cmd_ready) begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_req_reg  <= in_req;
            stg_key_reg  <= in_key;
            stg_prod_reg <= PROD_W'(sat_dur) * PROD_W'(RECIP_MUL);
        end
    end

    // Quotient times ten is the rounded count
    assign quot = stg_prod_reg[PROD_W-1:RECIP_SHIFT];

    assign cmd_valid = stg_valid_reg;
    assign cmd.req   = stg_req_reg;
    assign cmd.key   = stg_key_reg;
    assign cmd.count = DUR_W'({quot, 3'b000}) + DUR_W'({quot, 1'b0});

endmodule

// ===== rtl/core/stt_queue.sv =====
// Short command queue between the front end and the slot sequencer
`timescale 1ns / 1ps

module stt_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  stt_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output stt_pkg::cmd_t pop_data
);
    import stt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/stt_back.sv =====
// Back end: slot table and sequencer that scans one slot per cycle unless a pending expiry waits on the result output
`timescale 1ns / 1ps
`include "software_timer_table_assert.svh"

module stt_back #(
    parameter int SLOTS      = stt_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = stt_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = stt_pkg::COUNT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    input  stt_pkg::cmd_t    cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output stt_pkg::result_t res
);
    import stt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Slot table
    logic [SLOTS-1:0]      slot_valid_reg;
    logic [KEY_BITS-1:0]   slot_key_reg   [SLOTS];
    logic [COUNT_BITS-1:0] slot_count_reg [SLOTS];

    // Sequencer state
    back_state_t           state_reg;
    back_state_t           state_next;
    logic [IDX_W-1:0]      idx_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [COUNT_BITS-1:0] hit_cnt_reg;
    logic                  free_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic                  pend_valid_reg;
    logic [KEY_BITS-1:0]   pend_key_reg;

    // Output register
    logic                  out_valid_reg;
    result_t               out_data_reg;
    result_t               out_data_next;
    logic                  out_push;

    logic [KEY_BITS-1:0]   key_c;
    logic                  cur_valid;
    logic [KEY_BITS-1:0]   cur_key;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic                  is_tick;
    logic                  live;
    logic                  expire;
    logic                  can_push;
    logic                  step;
    logic                  finish;
    logic                  start_ok;
    logic [IDX_W-1:0]      sel_idx;

    assign key_c     = KEY_BITS'(cmd.key);
    assign cur_valid = slot_valid_reg[idx_reg];
    assign cur_key   = slot_key_reg[idx_reg];
    assign cur_cnt   = slot_count_reg[idx_reg];
    assign is_tick   = (cmd.req == REQ_TICK);
    assign live      = cur_valid && (cur_cnt != '0);
    assign expire    = live && (cur_cnt == COUNT_BITS'(1));
    assign can_push  = !out_valid_reg || res_ready;
    // Hold the scan while an expiry cannot leave
    assign step      = !(is_tick && expire && pend_valid_reg && !can_push);
    assign finish    = can_push || (is_tick && !pend_valid_reg);
    assign start_ok  = hit_reg || free_reg;
    assign sel_idx   = hit_reg ? hit_idx_reg : free_idx_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step && idx_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: result to push and queue pop
    always_comb begin
        out_push                = 1'b0;
        cmd_pop                 = 1'b0;
        out_data_next.kind      = EV_EXPIRY;
        out_data_next.ok        = 1'b1;
        out_data_next.key       = KEY_W'(pend_key_reg);
        out_data_next.remaining = '0;
        out_data_next.last      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_SCAN: begin
                out_push = is_tick && expire && pend_valid_reg && can_push;
            end
            ST_DONE: begin
                cmd_pop            = finish;
                out_data_next.last = 1'b1;
                unique case (cmd.req)
                    REQ_TICK: begin
                        out_push = pend_valid_reg && can_push;
                    end
                    REQ_START: begin
                        out_push                = can_push;
                        out_data_next.kind      = EV_START;
                        out_data_next.ok        = start_ok;
                        out_data_next.key       = KEY_W'(key_c);
                        out_data_next.remaining = start_ok ? cmd.count : '0;
                    end
                    REQ_DELETE: begin
                        out_push           = can_push;
                        out_data_next.kind = EV_DELETE;
                        out_data_next.ok   = hit_reg;
                        out_data_next.key  = KEY_W'(key_c);
                    end
                    REQ_READ: begin
                        out_push                = can_push;
                        out_data_next.kind      = EV_READ;
                        out_data_next.ok        = hit_reg;
                        out_data_next.key       = KEY_W'(key_c);
                        out_data_next.remaining = hit_reg ? DUR_W'(hit_cnt_reg) : '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    idx_reg  <= '0;
                    hit_reg  <= 1'b0;
                    free_reg <= 1'b0;
                end
                ST_SCAN: begin
                    if (step) begin
                        idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
                    end
                    if (is_tick) begin
                        if (step && expire) begin
                            pend_valid_reg <= 1'b1;
                        end
                    end else begin
                        if (cur_valid && cur_key == key_c && !hit_reg) begin
                            hit_reg <= 1'b1;
                        end
                        if (!cur_valid && !free_reg) begin
                            free_reg <= 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (finish) begin
                        pend_valid_reg <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Scan payload: match, first free slot, pending expiry key
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN) begin
            if (is_tick) begin
                if (step && expire) begin
                    pend_key_reg <= cur_key;
                end
            end else begin
                if (cur_valid && cur_key == key_c && !hit_reg) begin
                    hit_idx_reg <= idx_reg;
                    hit_cnt_reg <= cur_cnt;
                end
                if (!cur_valid && !free_reg) begin
                    free_idx_reg <= idx_reg;
                end
            end
        end
    end

    // Slot valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
        end else if (state_reg == ST_DONE && finish) begin
            if (cmd.req == REQ_START && start_ok) begin
                slot_valid_reg[sel_idx] <= 1'b1;
            end else if (cmd.req == REQ_DELETE && hit_reg) begin
                slot_valid_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    // Slot keys and counts: decrement on tick, load on start
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN && is_tick && step && live) begin
            slot_count_reg[idx_reg] <= cur_cnt - COUNT_BITS'(1);
        end else if (state_reg == ST_DONE && finish && cmd.req == REQ_START && start_ok) begin
            slot_key_reg[sel_idx]   <= key_c;
            slot_count_reg[sel_idx] <= COUNT_BITS'(cmd.count);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_push) begin
            out_valid_reg <= 1'b1;
        end else if (res_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_push) begin
            out_data_reg <= out_data_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    // An expiry never waits once the sequencer is back at rest
    `STT_ASSERT_IMP(a_idle_no_pend, aclk, aresetn, state_reg == ST_IDLE, !pend_valid_reg)
    // The scan index only moves inside a scan
    `STT_ASSERT_IMP(a_idx_in_scan, aclk, aresetn, idx_reg != '0, state_reg == ST_SCAN)
    // The command being worked on stays at the queue head
    `STT_ASSERT_IMP(a_cmd_held, aclk, aresetn, state_reg != ST_IDLE, cmd_valid)
    // Popping a command returns the sequencer to rest with a cleared index
    `STT_ASSERT_NXT(a_pop_rest, aclk, aresetn, cmd_pop, state_reg == ST_IDLE && idx_reg == '0)

endmodule

// ===== rtl/core/software_timer_table.sv =====
// Path: an item passes the front stage register, the command queue, the back end's scan and
//   its done state, and the output register; earlier expiries of a tick leave during the scan.
// The back end takes up the next queued command only once the last is done, scanning one slot
//   per cycle; a stalled result output stretches the scan or its done state by the stall.
// Reset: synchronous, active low; all slots are marked free at once, no clearing pass.
// Keys and counts of a slot are written before they are ever read.
`timescale 1ns / 1ps

module software_timer_table #(
    parameter int SLOTS      = stt_pkg::SLOTS_DEF,
    parameter int KEY_BITS   = stt_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = stt_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // timer_key[7:0], duration[31:8]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // ok[0], key_out[8:1], remaining[32:9], zero[39:33]
    output logic [1:0]  m_axis_tuser,   // event_kind[1:0]
    output logic        m_axis_tlast    // last
);
    import stt_pkg::*;

    logic    fr_valid;
    logic    fr_ready;
    cmd_t    fr_cmd;
    logic    q_valid;
    logic    q_pop;
    cmd_t    q_cmd;
    result_t res;

    // Accept and round incoming requests
    stt_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req      (req_t'(s_axis_tuser)),
        .in_key      (s_axis_tdata[7:0]),
        .in_duration (s_axis_tdata[31:8]),
        .cmd_valid   (fr_valid),
        .cmd_ready   (fr_ready),
        .cmd         (fr_cmd)
    );

    // Decouple front and back
    stt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_cmd)
    );

    // Carry out requests over the slot table
    stt_back #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .cmd       (q_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pack the result item
    assign m_axis_tdata = {7'd0, res.remaining, res.key, res.ok};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
